FILE: rtl/dpcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, codes and sizes of the disc pair collision resolver.
package dpcr_pkg;

  localparam int RADIUS_W   = 30;
  localparam int THRESH_W   = 17;
  localparam int CFG_W      = 30;
  localparam int FIFO_DEPTH = 4;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 30'd4294967;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 17'd65536;

  localparam logic [2:0] HEALTH_HEALTHY = 3'd0;
  localparam logic [2:0] HEALTH_ILL     = 3'd1;
  localparam logic [2:0] HEALTH_GONE    = 3'd4;

  typedef enum logic [0:0] {
    REG_DISC_RADIUS      = 1'b0,
    REG_SPREAD_THRESHOLD = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] first_pos_x;
    logic signed [31:0] first_pos_y;
    logic signed [31:0] first_vel_x;
    logic signed [31:0] first_vel_y;
    logic [2:0]         first_health;
    logic signed [31:0] second_pos_x;
    logic signed [31:0] second_pos_y;
    logic signed [31:0] second_vel_x;
    logic signed [31:0] second_vel_y;
    logic [2:0]         second_health;
    logic [15:0]        chance_draw;
  } req_t;

  typedef struct packed {
    logic               in_contact;
    logic signed [31:0] new_first_pos_x;
    logic signed [31:0] new_first_pos_y;
    logic signed [31:0] new_first_vel_x;
    logic signed [31:0] new_first_vel_y;
    logic [2:0]         new_first_health;
    logic signed [31:0] new_second_pos_x;
    logic signed [31:0] new_second_pos_y;
    logic signed [31:0] new_second_vel_x;
    logic signed [31:0] new_second_vel_y;
    logic [2:0]         new_second_health;
  } rsp_t;

  // A classified request as handed from the front end to the back end.
  typedef struct packed {
    req_t        req;
    logic        contact;
    logic [61:0] d2;
    logic [30:0] adx;
    logic [30:0] ady;
    logic        dxn;
    logic        dyn;
  } fr_item_t;

endpackage
`default_nettype wire

FILE: rtl/dpcr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Front end: accepts requests, tests contact and applies infection.
module dpcr_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     req_valid,
  output logic                          req_ready,
  input  wire dpcr_pkg::req_t           req_data,
  input  wire logic [29:0]              disc_radius,
  input  wire logic [16:0]              spread_threshold,
  output logic                          fr_valid,
  input  wire logic                     fr_ready,
  output dpcr_pkg::fr_item_t            fr_item
);
  import dpcr_pkg::*;

  logic        v1, v2;
  logic        adv1, adv2, adv3;
  req_t        f1_req, f2_req;
  logic [32:0] f1_adx, f1_ady;
  logic        f1_dxn, f1_dyn, f1_gone, f1_near;
  logic [61:0] f2_sqx, f2_sqy, f2_dd;
  logic [30:0] f2_adx, f2_ady;
  logic        f2_dxn, f2_dyn, f2_gone, f2_near;
  logic [30:0] span;
  logic [32:0] dx, dy, adx_in, ady_in;
  logic [62:0] d2sum;
  logic        contact, spread;
  logic [2:0]  h1, h2;
  fr_item_t    f3;

  assign span = {disc_radius, 1'b0};
  assign adv3 = !fr_valid || fr_ready;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign req_ready = adv1;

  always_comb begin
    dx = {req_data.first_pos_x[31], req_data.first_pos_x} -
         {req_data.second_pos_x[31], req_data.second_pos_x};
    dy = {req_data.first_pos_y[31], req_data.first_pos_y} -
         {req_data.second_pos_y[31], req_data.second_pos_y};
    adx_in = dx[32] ? 33'(-dx) : dx;
    ady_in = dy[32] ? 33'(-dy) : dy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      fr_valid <= 1'b0;
    end else begin
      if (adv1) v1 <= req_valid;
      if (adv2) v2 <= v1;
      if (adv3) fr_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      f1_req  <= req_data;
      f1_adx  <= adx_in;
      f1_ady  <= ady_in;
      f1_dxn  <= dx[32];
      f1_dyn  <= dy[32];
      f1_gone <= (req_data.first_health == HEALTH_GONE) ||
                 (req_data.second_health == HEALTH_GONE);
      f1_near <= (adx_in < {2'b00, span}) && (ady_in < {2'b00, span});
    end
    if (adv2) begin
      f2_req  <= f1_req;
      f2_sqx  <= f1_adx[30:0] * f1_adx[30:0];
      f2_sqy  <= f1_ady[30:0] * f1_ady[30:0];
      f2_dd   <= span * span;
      f2_adx  <= f1_adx[30:0];
      f2_ady  <= f1_ady[30:0];
      f2_dxn  <= f1_dxn;
      f2_dyn  <= f1_dyn;
      f2_gone <= f1_gone;
      f2_near <= f1_near;
    end
    if (adv3) fr_item <= f3;
  end

  always_comb begin
    d2sum   = {1'b0, f2_sqx} + {1'b0, f2_sqy};
    contact = !f2_gone && f2_near && (d2sum < {1'b0, f2_dd});
    spread  = contact && ({1'b0, f2_req.chance_draw} < spread_threshold);
    h2 = f2_req.second_health;
    if (spread && f2_req.first_health == HEALTH_ILL && h2 == HEALTH_HEALTHY) h2 = HEALTH_ILL;
    h1 = f2_req.first_health;
    if (spread && h2 == HEALTH_ILL && h1 == HEALTH_HEALTHY) h1 = HEALTH_ILL;
    f3 = '0;
    f3.req = f2_req;
    f3.req.first_health  = h1;
    f3.req.second_health = h2;
    f3.contact = contact;
    f3.d2      = d2sum[61:0];
    f3.adx     = f2_adx;
    f3.ady     = f2_ady;
    f3.dxn     = f2_dxn;
    f3.dyn     = f2_dyn;
  end

endmodule
`default_nettype wire

FILE: rtl/dpcr_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// Short queue of classified requests between the front and back ends.
module dpcr_fifo (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push_valid,
  output logic                     push_ready,
  input  wire dpcr_pkg::fr_item_t  push_item,
  output logic                     pop_valid,
  input  wire logic                pop_ready,
  output dpcr_pkg::fr_item_t       pop_item
);
  import dpcr_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  fr_item_t         mem [0:FIFO_DEPTH-1];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;
  logic             push, pop;

  assign push_ready = (count != (PTR_W+1)'(FIFO_DEPTH));
  assign pop_valid  = (count != '0);
  assign push = push_valid && push_ready;
  assign pop  = pop_valid && pop_ready;
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

endmodule
`default_nettype wire

FILE: rtl/dpcr_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Back end: separation and velocity exchange in a stalling pipeline.
module dpcr_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                fr_valid,
  output logic                     fr_ready,
  input  wire dpcr_pkg::fr_item_t  fr_item,
  input  wire logic [29:0]         disc_radius,
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  output dpcr_pkg::rsp_t           rsp_data
);
  import dpcr_pkg::*;

  localparam int QC_BITS = 35;
  localparam int SQ_BITS = 31;
  localparam int QP_BITS = 31;
  localparam int K_MT    = 0;
  localparam int K_DOT   = 1;
  localparam int K_PP    = 2;
  localparam int K_SUM   = 3;
  localparam int K_SQI   = K_SUM + 1 + QC_BITS;
  localparam int K_GAP   = K_SQI + 1 + SQ_BITS;
  localparam int NST     = K_GAP + 1 + QP_BITS;

  typedef struct packed {
    fr_item_t    fr;
    logic [62:0] mt_x;
    logic [62:0] mt_y;
    logic        mt_nx;
    logic        mt_ny;
    logic [63:0] dot;
    logic        dneg;
    logic [62:0] pl_x;
    logic [62:0] pl_y;
    logic [62:0] ph_x;
    logic [62:0] ph_y;
    logic [61:0] rem_x;
    logic [61:0] rem_y;
    logic [34:0] low_x;
    logic [34:0] low_y;
    logic [34:0] quo_x;
    logic [34:0] quo_y;
    logic [34:0] cq_x;
    logic [34:0] cq_y;
    logic [61:0] sq_rem;
    logic [30:0] sq_root;
  } bk_t;

  bk_t         st_in;
  bk_t         st  [1:NST];
  logic        vld [1:NST];
  logic        en;
  logic [30:0] span;

  assign span = {disc_radius, 1'b0};
  assign en = !rsp_valid || rsp_ready;
  assign fr_ready = en;

  function automatic bk_t f_mt(input bk_t x);
    bk_t         y;
    logic [32:0] dvx, dvy, avx, avy;
    logic [63:0] px, py;
    y = x;
    dvx = {x.fr.req.first_vel_x[31], x.fr.req.first_vel_x} -
          {x.fr.req.second_vel_x[31], x.fr.req.second_vel_x};
    dvy = {x.fr.req.first_vel_y[31], x.fr.req.first_vel_y} -
          {x.fr.req.second_vel_y[31], x.fr.req.second_vel_y};
    avx = dvx[32] ? 33'(-dvx) : dvx;
    avy = dvy[32] ? 33'(-dvy) : dvy;
    px = avx * x.fr.adx;
    py = avy * x.fr.ady;
    y.mt_x = px[62:0];
    y.mt_y = py[62:0];
    y.mt_nx = (dvx[32] ^ x.fr.dxn) && (dvx != '0) && (x.fr.adx != '0);
    y.mt_ny = (dvy[32] ^ x.fr.dyn) && (dvy != '0) && (x.fr.ady != '0);
    return y;
  endfunction

  function automatic bk_t f_dot(input bk_t x);
    bk_t y;
    y = x;
    if (x.mt_nx == x.mt_ny) begin
      y.dot  = {1'b0, x.mt_x} + {1'b0, x.mt_y};
      y.dneg = x.mt_nx;
    end else if (x.mt_x >= x.mt_y) begin
      y.dot  = {1'b0, x.mt_x - x.mt_y};
      y.dneg = x.mt_nx;
    end else begin
      y.dot  = {1'b0, x.mt_y - x.mt_x};
      y.dneg = x.mt_ny;
    end
    return y;
  endfunction

  function automatic bk_t f_pp(input bk_t x);
    bk_t y;
    y = x;
    y.pl_x = x.fr.adx * x.dot[31:0];
    y.ph_x = x.fr.adx * x.dot[63:32];
    y.pl_y = x.fr.ady * x.dot[31:0];
    y.ph_y = x.fr.ady * x.dot[63:32];
    return y;
  endfunction

  function automatic bk_t f_sum(input bk_t x);
    bk_t         y;
    logic [94:0] nx, ny;
    y = x;
    nx = {32'b0, x.pl_x} + {x.ph_x, 32'b0};
    ny = {32'b0, x.pl_y} + {x.ph_y, 32'b0};
    y.rem_x = {2'b00, nx[94:35]};
    y.rem_y = {2'b00, ny[94:35]};
    y.low_x = nx[34:0];
    y.low_y = ny[34:0];
    y.quo_x = '0;
    y.quo_y = '0;
    return y;
  endfunction

  function automatic bk_t div_step(input bk_t x, input logic [61:0] dv);
    bk_t         y;
    logic [62:0] tx, ty;
    logic        bx, by;
    y = x;
    tx = {x.rem_x, x.low_x[34]};
    ty = {x.rem_y, x.low_y[34]};
    bx = (tx >= {1'b0, dv});
    by = (ty >= {1'b0, dv});
    y.rem_x = bx ? 62'(tx - {1'b0, dv}) : tx[61:0];
    y.rem_y = by ? 62'(ty - {1'b0, dv}) : ty[61:0];
    y.low_x = {x.low_x[33:0], 1'b0};
    y.low_y = {x.low_y[33:0], 1'b0};
    y.quo_x = {x.quo_x[33:0], bx};
    y.quo_y = {x.quo_y[33:0], by};
    return y;
  endfunction

  function automatic bk_t f_sqi(input bk_t x);
    bk_t y;
    y = x;
    y.cq_x = x.quo_x;
    y.cq_y = x.quo_y;
    y.sq_rem = x.fr.d2;
    y.sq_root = '0;
    return y;
  endfunction

  function automatic bk_t sq_step(input bk_t x, input int i);
    bk_t         y;
    logic [62:0] inc;
    y = x;
    inc = ({32'b0, x.sq_root} << (i + 1)) + (63'd1 << (2 * i));
    if ({1'b0, x.sq_rem} >= inc) begin
      y.sq_rem  = x.sq_rem - inc[61:0];
      y.sq_root = x.sq_root | (31'd1 << i);
    end
    return y;
  endfunction

  function automatic bk_t f_gap(input bk_t x, input logic [30:0] dd);
    bk_t         y;
    logic [30:0] gap;
    logic [61:0] gx, gy;
    y = x;
    gap = dd - x.sq_root;
    gx = gap * x.fr.adx;
    gy = gap * x.fr.ady;
    y.rem_x = {31'b0, gx[61:31]};
    y.rem_y = {31'b0, gy[61:31]};
    y.low_x = {gx[30:0], 4'b0000};
    y.low_y = {gy[30:0], 4'b0000};
    y.quo_x = '0;
    y.quo_y = '0;
    return y;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    if (v[36:31] == {6{v[36]}}) return v[31:0];
    return v[36] ? 32'sh80000000 : 32'sh7FFFFFFF;
  endfunction

  function automatic rsp_t f_out(input bk_t x);
    rsp_t               r;
    logic signed [36:0] m, c;
    logic               cneg;
    req_t               q;
    q = x.fr.req;
    r.in_contact        = x.fr.contact;
    r.new_first_pos_x   = q.first_pos_x;
    r.new_first_pos_y   = q.first_pos_y;
    r.new_first_vel_x   = q.first_vel_x;
    r.new_first_vel_y   = q.first_vel_y;
    r.new_first_health  = q.first_health;
    r.new_second_pos_x  = q.second_pos_x;
    r.new_second_pos_y  = q.second_pos_y;
    r.new_second_vel_x  = q.second_vel_x;
    r.new_second_vel_y  = q.second_vel_y;
    r.new_second_health = q.second_health;
    if (x.fr.contact && x.fr.d2 != '0) begin
      m = {6'b0, x.quo_x[30:0]};
      if (x.fr.dxn) m = -m;
      r.new_first_pos_x  = sat32(37'(q.first_pos_x) + m);
      r.new_second_pos_x = sat32(37'(q.second_pos_x) - m);
      m = {6'b0, x.quo_y[30:0]};
      if (x.fr.dyn) m = -m;
      r.new_first_pos_y  = sat32(37'(q.first_pos_y) + m);
      r.new_second_pos_y = sat32(37'(q.second_pos_y) - m);
      cneg = x.dneg ^ x.fr.dxn;
      c = {2'b00, x.cq_x};
      if (cneg) c = -c;
      r.new_first_vel_x  = sat32(37'(q.first_vel_x) - c);
      r.new_second_vel_x = sat32(37'(q.second_vel_x) + c);
      cneg = x.dneg ^ x.fr.dyn;
      c = {2'b00, x.cq_y};
      if (cneg) c = -c;
      r.new_first_vel_y  = sat32(37'(q.first_vel_y) - c);
      r.new_second_vel_y = sat32(37'(q.second_vel_y) + c);
    end
    return r;
  endfunction

  always_comb begin
    st_in = '0;
    st_in.fr = fr_item;
  end

  for (genvar k = 0; k < NST; k++) begin : g_stage
    if (k == 0) begin : g_v0
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k+1] <= 1'b0;
        end else if (en) begin
          vld[k+1] <= fr_valid;
        end
      end
    end else begin : g_vn
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k+1] <= 1'b0;
        end else if (en) begin
          vld[k+1] <= vld[k];
        end
      end
    end

    if (k == K_MT) begin : g_mt
      always_ff @(posedge clk) if (en) st[k+1] <= f_mt(st_in);
    end else if (k == K_DOT) begin : g_dot
      always_ff @(posedge clk) if (en) st[k+1] <= f_dot(st[k]);
    end else if (k == K_PP) begin : g_pp
      always_ff @(posedge clk) if (en) st[k+1] <= f_pp(st[k]);
    end else if (k == K_SUM) begin : g_sum
      always_ff @(posedge clk) if (en) st[k+1] <= f_sum(st[k]);
    end else if (k < K_SQI) begin : g_cdiv
      always_ff @(posedge clk) if (en) st[k+1] <= div_step(st[k], st[k].fr.d2);
    end else if (k == K_SQI) begin : g_sqi
      always_ff @(posedge clk) if (en) st[k+1] <= f_sqi(st[k]);
    end else if (k < K_GAP) begin : g_sqrt
      always_ff @(posedge clk) if (en) st[k+1] <= sq_step(st[k], SQ_BITS - (k - K_SQI));
    end else if (k == K_GAP) begin : g_gap
      always_ff @(posedge clk) if (en) st[k+1] <= f_gap(st[k], span);
    end else begin : g_pdiv
      always_ff @(posedge clk) begin
        if (en) st[k+1] <= div_step(st[k], {30'b0, st[k].sq_root, 1'b0});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= vld[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) rsp_data <= f_out(st[NST]);
  end

endmodule
`default_nettype wire

FILE: rtl/disc_pair_collision_resolver.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the disc pair collision resolver with its configuration registers.
//
//   channel   signals                          payload
//   request   req_valid / req_ready            req_data  (req_t)
//   response  rsp_valid / rsp_ready            rsp_data  (rsp_t)
//   config    cfg_we                           cfg_index, cfg_data
//
// One request is taken per cycle while the queue has room to let the front end advance;
// the latency is set by the bit-serial square root and the two divider chains.
// Reset is synchronous and clears only control state and the registers.
// A stalled response freezes the back end; the queue lets the front end keep
// taking requests until it fills.
module disc_pair_collision_resolver (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_ready,
  input  wire dpcr_pkg::req_t       req_data,
  output logic                      rsp_valid,
  input  wire logic                 rsp_ready,
  output dpcr_pkg::rsp_t            rsp_data,
  input  wire logic                 cfg_we,
  input  wire logic [0:0]           cfg_index,
  input  wire logic [29:0]          cfg_data
);
  import dpcr_pkg::*;

  logic [RADIUS_W-1:0] disc_radius;
  logic [THRESH_W-1:0] spread_threshold;
  logic                f_valid, f_ready, b_valid, b_ready;
  fr_item_t            f_item, b_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      disc_radius      <= RADIUS_RESET;
      spread_threshold <= THRESH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DISC_RADIUS:      disc_radius <= cfg_data;
        REG_SPREAD_THRESHOLD: spread_threshold <= cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  dpcr_front u_front (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_ready        (req_ready),
    .req_data         (req_data),
    .disc_radius      (disc_radius),
    .spread_threshold (spread_threshold),
    .fr_valid         (f_valid),
    .fr_ready         (f_ready),
    .fr_item          (f_item)
  );

  dpcr_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_item   (b_item)
  );

  dpcr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .fr_valid    (b_valid),
    .fr_ready    (b_ready),
    .fr_item     (b_item),
    .disc_radius (disc_radius),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp_data    (rsp_data)
  );

endmodule
`default_nettype wire

FILE: dv/tb_disc_pair_collision_resolver.sv
`timescale 1ns / 1ps
// Self-checking testbench of the disc pair collision resolver with a built-in predictor.
module tb_disc_pair_collision_resolver;
  import dpcr_pkg::*;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  req_t        req_data;
  logic        rsp_valid;
  logic        rsp_ready;
  rsp_t        rsp_data;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [29:0] cfg_data;

  disc_pair_collision_resolver dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic [29:0] radius_now;
  logic [16:0] thresh_now;
  req_t        pending_pairs[$];
  rsp_t        resolved_q[$];
  bit          calm;
  int          errors;
  int          contacts;
  int          resolved;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -64'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic rsp_t resolve_pair(req_t q);
    rsp_t            o;
    longint          p1x, p1y, p2x, p2y, v1x, v1y, v2x, v2y;
    longint          dx, dy, ax, ay, mx, my, dot, cx, cy;
    longint unsigned dd, d2, s, gap, adot;
    logic [127:0]    quo;
    logic [2:0]      h1, h2;
    bit              touch;
    p1x = q.first_pos_x;  p1y = q.first_pos_y;
    v1x = q.first_vel_x;  v1y = q.first_vel_y;
    p2x = q.second_pos_x; p2y = q.second_pos_y;
    v2x = q.second_vel_x; v2y = q.second_vel_y;
    h1 = q.first_health;
    h2 = q.second_health;
    dd = 2 * longint'(radius_now);
    dx = p1x - p2x;
    dy = p1y - p2y;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    touch = 1'b0;
    d2 = 0;
    if (h1 != HEALTH_GONE && h2 != HEALTH_GONE && ax < dd && ay < dd) begin
      d2 = ax * ax + ay * ay;
      touch = d2 < dd * dd;
    end
    if (touch) begin
      if (q.chance_draw < thresh_now) begin
        if (h1 == HEALTH_ILL && h2 == HEALTH_HEALTHY) h2 = HEALTH_ILL;
        if (h2 == HEALTH_ILL && h1 == HEALTH_HEALTHY) h1 = HEALTH_ILL;
      end
      if (d2 != 0) begin
        s = root_floor(d2);
        gap = dd - s;
        mx = (gap * ax) / (2 * s);
        my = (gap * ay) / (2 * s);
        if (dx < 0) mx = -mx;
        if (dy < 0) my = -my;
        p1x = clamp32(p1x + mx); p1y = clamp32(p1y + my);
        p2x = clamp32(p2x - mx); p2y = clamp32(p2y - my);
        dot = (v1x - v2x) * dx + (v1y - v2y) * dy;
        adot = dot < 0 ? -dot : dot;
        quo = (128'(ax) * 128'(adot)) / 128'(d2);
        if (quo > (128'd1 << 40)) quo = 128'd1 << 40;
        cx = ((dot < 0) != (dx < 0)) ? -longint'(quo) : longint'(quo);
        quo = (128'(ay) * 128'(adot)) / 128'(d2);
        if (quo > (128'd1 << 40)) quo = 128'd1 << 40;
        cy = ((dot < 0) != (dy < 0)) ? -longint'(quo) : longint'(quo);
        v1x = clamp32(v1x - cx); v1y = clamp32(v1y - cy);
        v2x = clamp32(v2x + cx); v2y = clamp32(v2y + cy);
      end
    end
    o.in_contact        = touch;
    o.new_first_pos_x   = p1x[31:0];
    o.new_first_pos_y   = p1y[31:0];
    o.new_first_vel_x   = v1x[31:0];
    o.new_first_vel_y   = v1y[31:0];
    o.new_first_health  = h1;
    o.new_second_pos_x  = p2x[31:0];
    o.new_second_pos_y  = p2y[31:0];
    o.new_second_vel_x  = v2x[31:0];
    o.new_second_vel_y  = v2y[31:0];
    o.new_second_health = h2;
    return o;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      errors++;
      $display("mismatch on response %0d: %s got %h expected %h", resolved, field, got, want);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) resolved_q = {resolved_q, resolve_pair(req_data)};
      if (!req_valid || req_ready) begin
        if (pending_pairs.size() > 0 && (calm || $urandom_range(99) >= 24)) begin
          req_data  <= pending_pairs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= calm || $urandom_range(99) >= 24;
      if (rsp_valid && rsp_ready) begin
        if (resolved_q.size() == 0) begin
          errors++;
          $display("response %0d arrived with no request outstanding", resolved);
        end else begin
          want = resolved_q.pop_front();
          report("in_contact", rsp_data.in_contact, want.in_contact);
          report("new_first_pos_x", rsp_data.new_first_pos_x, want.new_first_pos_x);
          report("new_first_pos_y", rsp_data.new_first_pos_y, want.new_first_pos_y);
          report("new_first_vel_x", rsp_data.new_first_vel_x, want.new_first_vel_x);
          report("new_first_vel_y", rsp_data.new_first_vel_y, want.new_first_vel_y);
          report("new_first_health", rsp_data.new_first_health, want.new_first_health);
          report("new_second_pos_x", rsp_data.new_second_pos_x, want.new_second_pos_x);
          report("new_second_pos_y", rsp_data.new_second_pos_y, want.new_second_pos_y);
          report("new_second_vel_x", rsp_data.new_second_vel_x, want.new_second_vel_x);
          report("new_second_vel_y", rsp_data.new_second_vel_y, want.new_second_vel_y);
          report("new_second_health", rsp_data.new_second_health, want.new_second_health);
          if (want.in_contact) contacts++;
        end
        resolved++;
      end
    end
  end

  function automatic logic [2:0] pick_health();
    if ($urandom_range(99) < 30) return 3'($urandom_range(7));
    return 3'($urandom_range(1));
  endfunction

  function automatic logic signed [31:0] pick_vel();
    if ($urandom_range(3) == 0) return 32'($urandom);
    return 32'($signed($urandom_range(2000000)) - 1000000);
  endfunction

  // Builds a pair whose centres differ by at most twice the radius less one on each axis when near is set.
  function automatic req_t make_pair(bit near);
    req_t   q;
    longint span;
    longint ox, oy;
    q.first_pos_x   = 32'($urandom);
    q.first_pos_y   = 32'($urandom);
    q.first_vel_x   = pick_vel();
    q.first_vel_y   = pick_vel();
    q.first_health  = pick_health();
    q.second_vel_x  = pick_vel();
    q.second_vel_y  = pick_vel();
    q.second_health = pick_health();
    q.chance_draw   = 16'($urandom);
    span = 2 * longint'(radius_now) - 1;
    ox = 0;
    oy = 0;
    if (near && span > 0) begin
      ox = longint'($urandom_range(32'(2 * span))) - span;
      oy = longint'($urandom_range(32'(2 * span))) - span;
      if ($urandom_range(9) == 0) oy = 0;
    end
    q.second_pos_x = near ? 32'(q.first_pos_x - ox) : 32'($urandom);
    q.second_pos_y = near ? 32'(q.first_pos_y - oy) : 32'($urandom);
    return q;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [29:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == REG_DISC_RADIUS) radius_now = value;
    else thresh_now = value[16:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_pairs.size() > 0 || req_valid || resolved_q.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic random_pairs(int count);
    repeat (count) pending_pairs = {pending_pairs, make_pair($urandom_range(99) < 75)};
  endtask

  initial begin
    req_t q;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_DISC_RADIUS;
    cfg_data = '0;
    radius_now = RADIUS_RESET;
    thresh_now = THRESH_RESET;
    calm = 1'b0;
    errors = 0;
    contacts = 0;
    resolved = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed requests at the reset settings, then at a radius of 536870912.
    q = make_pair(1'b1);
    q.first_health = HEALTH_ILL; q.second_health = HEALTH_HEALTHY; q.chance_draw = 16'hFFFF;
    pending_pairs = {pending_pairs, q};
    q.first_health = HEALTH_HEALTHY; q.second_health = HEALTH_ILL;
    pending_pairs = {pending_pairs, q};
    q.first_health = HEALTH_GONE;
    pending_pairs = {pending_pairs, q};
    q.first_health = 3'd7; q.second_health = 3'd5;
    pending_pairs = {pending_pairs, q};
    q.first_health = HEALTH_ILL; q.second_health = HEALTH_HEALTHY;
    q.second_pos_x = q.first_pos_x; q.second_pos_y = q.first_pos_y;
    pending_pairs = {pending_pairs, q};
    q = make_pair(1'b0);
    pending_pairs = {pending_pairs, q};
    q = make_pair(1'b1);
    q.second_pos_x = q.first_pos_x + 1; q.second_pos_y = q.first_pos_y;
    q.first_vel_x = 32'sh7FFFFFFF; q.second_vel_x = 32'sh80000000;
    pending_pairs = {pending_pairs, q};
    random_pairs(40);
    drain();

    write_reg(REG_DISC_RADIUS, 30'd536870912);
    write_reg(REG_SPREAD_THRESHOLD, 30'd0);
    q = make_pair(1'b1);
    q.first_pos_x = 32'sh7FFFFFF0; q.second_pos_x = 32'sh7FFFFFF0 - 32'sd4;
    q.first_pos_y = 32'sh80000010; q.second_pos_y = 32'sh80000010 + 32'sd3;
    q.first_vel_x = 32'sh80000000; q.second_vel_x = 32'sh7FFFFFFF;
    q.first_vel_y = 32'sh7FFFFFFF; q.second_vel_y = 32'sh80000000;
    pending_pairs = {pending_pairs, q};
    q.second_pos_x = 32'sh7FFFFFF0 - 32'sh3FFFFFFF; q.second_pos_y = q.first_pos_y;
    pending_pairs = {pending_pairs, q};
    q.second_pos_y = q.first_pos_y + 32'sh3FFFFFFF;
    pending_pairs = {pending_pairs, q};
    q.first_health = HEALTH_ILL; q.second_health = HEALTH_HEALTHY; q.chance_draw = 16'h0000;
    pending_pairs = {pending_pairs, q};
    random_pairs(80);
    drain();

    write_reg(REG_DISC_RADIUS, 30'd0);
    write_reg(REG_SPREAD_THRESHOLD, 30'd65536);
    q = make_pair(1'b1);
    q.second_pos_x = q.first_pos_x; q.second_pos_y = q.first_pos_y;
    pending_pairs = {pending_pairs, q};
    random_pairs(20);
    drain();

    calm = 1'b1;
    write_reg(REG_DISC_RADIUS, 30'd1000);
    write_reg(REG_SPREAD_THRESHOLD, 30'd32768);
    random_pairs(90);
    drain();
    calm = 1'b0;

    write_reg(REG_DISC_RADIUS, 30'd3);
    write_reg(REG_SPREAD_THRESHOLD, 30'd65535);
    random_pairs(60);
    drain();

    repeat (3) begin
      write_reg(REG_DISC_RADIUS, 30'($urandom_range(536870912)));
      write_reg(REG_SPREAD_THRESHOLD, 30'($urandom_range(65536)));
      random_pairs(80);
      drain();
    end

    $display("Resolved %0d pairs over eight register settings, %0d of them in contact.",
             resolved, contacts);
    $display("Radius ranged from zero to the largest value, threshold from never to always.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
